// File: hdl/dta_pkg.sv
// shared constants, types and calendar helpers for the date/time advance block
package dta_pkg;

  localparam int ADD_MINUTES_WIDTH_DEF = 16;

  localparam int MIN_PER_DAY     = 1440;
  localparam int MIN_PER_HOUR    = 60;
  localparam int YEARS_PER_CENT  = 100;
  localparam int YEAR_TOP        = 9999;
  localparam int MONTHS_PER_YEAR = 12;
  localparam int CARRY_MAX       = 63;

  localparam int DAY_W    = 5;
  localparam int MONTH_W  = 4;
  localparam int YEAR_W   = 14;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int CARRY_W  = 6;
  localparam int TOD_W    = 11;
  localparam int REM_W    = 12;
  localparam int CENT_W   = 7;
  localparam int QUAD_W   = 2;

  localparam logic [MONTH_W-1:0] M_JAN = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] M_FEB = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] M_APR = MONTH_W'(4);
  localparam logic [MONTH_W-1:0] M_JUN = MONTH_W'(6);
  localparam logic [MONTH_W-1:0] M_SEP = MONTH_W'(9);
  localparam logic [MONTH_W-1:0] M_NOV = MONTH_W'(11);
  localparam logic [MONTH_W-1:0] M_DEC = MONTH_W'(MONTHS_PER_YEAR);

  // divider pass select: which constant divides the dividend
  localparam int DIV_SEL_W = 2;
  localparam logic [DIV_SEL_W-1:0] DIV_DAY  = DIV_SEL_W'(0);
  localparam logic [DIV_SEL_W-1:0] DIV_HOUR = DIV_SEL_W'(1);
  localparam logic [DIV_SEL_W-1:0] DIV_CENT = DIV_SEL_W'(2);

  typedef struct packed {
    logic                 start;
    logic [DIV_SEL_W-1:0] sel;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [REM_W-1:0] rem;
  } div_rsp_t;

  // width of start-of-day minutes plus offset
  function automatic int end_width(input int add_w);
    return ((add_w > TOD_W) ? add_w : TOD_W) + 1;
  endfunction

  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] month,
                                                  input logic leap);
    logic [DAY_W-1:0] len;
    if (month == M_FEB) begin
      len = leap ? DAY_W'(29) : DAY_W'(28);
    end else if (month == M_APR || month == M_JUN || month == M_SEP || month == M_NOV) begin
      len = DAY_W'(30);
    end else begin
      len = DAY_W'(31);
    end
    return len;
  endfunction

endpackage

// File: hdl/date_time_advance_core.sv
// top level: advances a date and time of day by a minute offset
//
// usage: present a word on the in_ ports with start high while busy is low;
// the word is taken at that edge and busy rises at once. One shared constant
// divider then runs three passes: minutes since midnight by 1440 (day carry
// and time of day), the time of day by 60 (hour and minute), and the year by
// 100 (century position for the leap rule). Each pass is a reciprocal
// estimate and one correction step.
// A month walk follows, advancing one month at a time until the day fits.
// The result word is on the out_ ports for one cycle with out_valid high
// once the walk ends (at the default width at most two months are crossed);
// busy falls in the cycle after, so no new word is taken before the result
// has left.
// The receiver cannot stall: out_valid is a strobe and the out_ ports hold
// the last word only until a new word is taken.
// Reset (rst_n low at a clock edge) drops busy and out_valid; a word in
// flight is lost.
module date_time_advance_core #(
  parameter int ADD_MINUTES_WIDTH = dta_pkg::ADD_MINUTES_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [4:0]                   in_start_day,
  input  logic [3:0]                   in_start_month,
  input  logic [13:0]                  in_start_year,
  input  logic [4:0]                   in_start_hour,
  input  logic [5:0]                   in_start_minute,
  input  logic [ADD_MINUTES_WIDTH-1:0] in_add_minutes,
  output logic                         out_valid,
  output logic [4:0]                   out_new_day,
  output logic [3:0]                   out_new_month,
  output logic [13:0]                  out_new_year,
  output logic [4:0]                   out_new_hour,
  output logic [5:0]                   out_new_minute,
  output logic [5:0]                   out_days_carried,
  output logic                         out_year_overflow
);

  localparam int DAY_W    = dta_pkg::DAY_W;
  localparam int MONTH_W  = dta_pkg::MONTH_W;
  localparam int YEAR_W   = dta_pkg::YEAR_W;
  localparam int HOUR_W   = dta_pkg::HOUR_W;
  localparam int MINUTE_W = dta_pkg::MINUTE_W;
  localparam int CARRY_W  = dta_pkg::CARRY_W;
  localparam int TOD_W    = dta_pkg::TOD_W;
  localparam int CENT_W   = dta_pkg::CENT_W;
  localparam int QUAD_W   = dta_pkg::QUAD_W;
  localparam int EW       = dta_pkg::end_width(ADD_MINUTES_WIDTH);
  localparam int DW       = (EW > YEAR_W) ? EW : YEAR_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DAY  = 3'd1;
  localparam logic [2:0] S_HOUR = 3'd2;
  localparam logic [2:0] S_YEAR = 3'd3;
  localparam logic [2:0] S_WALK = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]         state_r;
  logic [2:0]         state_nxt;
  logic               start_ge_r;
  logic [EW-1:0]      carried_r;
  logic [EW:0]        day_acc_r;
  logic [MONTH_W-1:0] month_r;
  logic [YEAR_W-1:0]  year_r;
  logic [CENT_W-1:0]  cent_r;
  logic [QUAD_W-1:0]  quad_r;
  logic [HOUR_W-1:0]  hour_r;
  logic [MINUTE_W-1:0] minute_r;
  logic               ovf_r;

  logic               accept;
  logic [TOD_W-1:0]   start_min;
  logic [EW-1:0]      end_min;
  logic               leap;
  logic [DAY_W-1:0]   len;
  logic               advance;

  dta_pkg::div_req_t  div_req;
  dta_pkg::div_rsp_t  div_rsp;
  logic [DW-1:0]      div_dvd;
  logic [DW-1:0]      div_quo;

  assign accept    = start && (state_r == S_IDLE);
  assign busy      = (state_r != S_IDLE);
  assign start_min = TOD_W'(in_start_hour) * TOD_W'(dta_pkg::MIN_PER_HOUR)
                     + TOD_W'(in_start_minute);
  assign end_min   = EW'(start_min) + EW'(in_add_minutes);

  // divisible by 4, and not a century unless the century count is a multiple of 4
  assign leap    = (year_r[1:0] == 2'b00) && ((cent_r != '0) || (quad_r == '0));
  assign len     = dta_pkg::month_days(month_r, leap);
  assign advance = (day_acc_r > (EW+1)'(len));

  always_comb begin
    div_req.start = accept || (div_rsp.done && (state_r == S_DAY || state_r == S_HOUR));
    div_req.sel   = dta_pkg::DIV_DAY;
    div_dvd       = DW'(end_min);
    unique case (state_r)
      S_DAY: begin
        div_req.sel = dta_pkg::DIV_HOUR;
        div_dvd     = DW'(div_rsp.rem);
      end
      S_HOUR: begin
        div_req.sel = dta_pkg::DIV_CENT;
        div_dvd     = DW'(year_r);
      end
      default: begin
        div_req.sel = dta_pkg::DIV_DAY;
        div_dvd     = DW'(end_min);
      end
    endcase
  end

  dta_divider #(
    .DW (DW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .dividend (div_dvd),
    .rsp      (div_rsp),
    .quotient (div_quo)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (start) state_nxt = S_DAY;
      S_DAY:  if (div_rsp.done) state_nxt = S_HOUR;
      S_HOUR: if (div_rsp.done) state_nxt = S_YEAR;
      S_YEAR: if (div_rsp.done) state_nxt = S_WALK;
      S_WALK: if (!advance) state_nxt = S_OUT;
      S_OUT:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      day_acc_r  <= (EW+1)'(in_start_day);
      month_r    <= in_start_month;
      year_r     <= in_start_year;
      start_ge_r <= (start_min >= TOD_W'(dta_pkg::MIN_PER_DAY));
      ovf_r      <= 1'b0;
    end
    if (state_r == S_DAY && div_rsp.done) begin
      carried_r <= div_quo[EW-1:0] - EW'(start_ge_r);
    end
    if (state_r == S_HOUR && div_rsp.done) begin
      hour_r   <= div_quo[HOUR_W-1:0];
      minute_r <= div_rsp.rem[MINUTE_W-1:0];
    end
    if (state_r == S_YEAR && div_rsp.done) begin
      cent_r    <= div_rsp.rem[CENT_W-1:0];
      quad_r    <= div_quo[QUAD_W-1:0];
      day_acc_r <= day_acc_r + (EW+1)'(carried_r);
    end
    if (state_r == S_WALK && advance) begin
      day_acc_r <= day_acc_r - (EW+1)'(len);
      if (month_r >= dta_pkg::M_DEC) begin
        month_r <= dta_pkg::M_JAN;
        if (year_r >= YEAR_W'(dta_pkg::YEAR_TOP)) begin
          year_r <= '0;
          cent_r <= '0;
          quad_r <= '0;
          ovf_r  <= 1'b1;
        end else begin
          year_r <= year_r + YEAR_W'(1);
          if (cent_r == CENT_W'(dta_pkg::YEARS_PER_CENT - 1)) begin
            cent_r <= '0;
            quad_r <= quad_r + QUAD_W'(1);
          end else begin
            cent_r <= cent_r + CENT_W'(1);
          end
        end
      end else begin
        month_r <= month_r + MONTH_W'(1);
      end
    end
  end

  assign out_valid         = (state_r == S_OUT);
  assign out_new_day       = day_acc_r[DAY_W-1:0];
  assign out_new_month     = month_r;
  assign out_new_year      = year_r;
  assign out_new_hour      = hour_r;
  assign out_new_minute    = minute_r;
  assign out_days_carried  = (carried_r > EW'(dta_pkg::CARRY_MAX)) ?
                             CARRY_W'(dta_pkg::CARRY_MAX) : carried_r[CARRY_W-1:0];
  assign out_year_overflow = ovf_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> (!out_valid && !busy))
    else $error("result strobe longer than one cycle");

  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_new_hour < HOUR_W'(24)) && (out_new_minute < MINUTE_W'(60))))
    else $error("time of day out of range");

  a_walk_leaves_day: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK && !advance) |=> out_valid)
    else $error("month walk ended without a result");

endmodule

// File: hdl/dta_divider.sv
// shared constant divider: reciprocal estimate, then one correction step
module dta_divider #(
  parameter int DW = 17
) (
  input  logic                clk,
  input  logic                rst_n,
  input  dta_pkg::div_req_t   req,
  input  logic [DW-1:0]       dividend,
  output dta_pkg::div_rsp_t   rsp,
  output logic [DW-1:0]       quotient
);

  localparam int REM_W = dta_pkg::REM_W;
  localparam int SEL_W = dta_pkg::DIV_SEL_W;

  // floor(2**DW / d): the estimate is low by at most one for any DW-bit dividend
  localparam logic [DW-1:0] RCP_DAY  = DW'((64'd1 << DW) / 64'(dta_pkg::MIN_PER_DAY));
  localparam logic [DW-1:0] RCP_HOUR = DW'((64'd1 << DW) / 64'(dta_pkg::MIN_PER_HOUR));
  localparam logic [DW-1:0] RCP_CENT = DW'((64'd1 << DW) / 64'(dta_pkg::YEARS_PER_CENT));

  logic             busy_r;
  logic             fix_r;
  logic             done_r;
  logic [SEL_W-1:0] sel_r;
  logic [DW-1:0]    dvd_r;
  logic [DW-1:0]    qest_r;
  logic [DW-1:0]    quo_r;
  logic [REM_W-1:0] rem_r;

  logic [DW-1:0]    rcp;
  logic [DW-1:0]    dsr;
  logic [2*DW-1:0]  prod;
  logic [DW-1:0]    rem_raw;
  logic             fits;
  logic [DW-1:0]    rem_dif;

  always_comb begin
    unique case (sel_r)
      dta_pkg::DIV_HOUR: begin
        rcp = RCP_HOUR;
        dsr = DW'(dta_pkg::MIN_PER_HOUR);
      end
      dta_pkg::DIV_CENT: begin
        rcp = RCP_CENT;
        dsr = DW'(dta_pkg::YEARS_PER_CENT);
      end
      default: begin
        rcp = RCP_DAY;
        dsr = DW'(dta_pkg::MIN_PER_DAY);
      end
    endcase
    prod    = (2*DW)'(dvd_r) * (2*DW)'(rcp);
    // remainder of the estimate is below twice the divisor
    rem_raw = dvd_r - qest_r * dsr;
    fits    = (rem_raw >= dsr);
    rem_dif = rem_raw - dsr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fix_r  <= 1'b0;
      done_r <= 1'b0;
      sel_r  <= dta_pkg::DIV_DAY;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        fix_r  <= 1'b0;
        sel_r  <= req.sel;
      end else if (busy_r && !fix_r) begin
        fix_r <= 1'b1;
      end else if (busy_r) begin
        busy_r <= 1'b0;
        fix_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy_r) begin
      dvd_r <= dividend;
    end else if (busy_r && !fix_r) begin
      qest_r <= prod[2*DW-1:DW];
    end else if (busy_r) begin
      quo_r <= qest_r + DW'(fits);
      rem_r <= fits ? rem_dif[REM_W-1:0] : rem_raw[REM_W-1:0];
    end
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;
  assign quotient = quo_r;

endmodule

// File: tb/date_time_advance_checker.sv
`timescale 1ns / 100ps
// checker for the date/time advance block: predicts each timestamp word and compares
module date_time_advance_checker #(
  parameter int ADD_W = dta_pkg::ADD_MINUTES_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             busy,
  input  logic [4:0]       in_start_day,
  input  logic [3:0]       in_start_month,
  input  logic [13:0]      in_start_year,
  input  logic [4:0]       in_start_hour,
  input  logic [5:0]       in_start_minute,
  input  logic [ADD_W-1:0] in_add_minutes,
  input  logic             out_valid,
  input  logic [4:0]       out_new_day,
  input  logic [3:0]       out_new_month,
  input  logic [13:0]      out_new_year,
  input  logic [4:0]       out_new_hour,
  input  logic [5:0]       out_new_minute,
  input  logic [5:0]       out_days_carried,
  input  logic             out_year_overflow,
  output int unsigned      fail_count,
  output int unsigned      pending
);

  typedef struct packed {
    logic [dta_pkg::DAY_W-1:0]    day;
    logic [dta_pkg::MONTH_W-1:0]  month;
    logic [dta_pkg::YEAR_W-1:0]   year;
    logic [dta_pkg::HOUR_W-1:0]   hour;
    logic [dta_pkg::MINUTE_W-1:0] minute;
    logic [dta_pkg::CARRY_W-1:0]  carried;
    logic                         overflow;
  } stamp_t;

  stamp_t stamp_q[$];

  function automatic bit leap_year(input int unsigned yr);
    return (yr % 4 == 0) && ((yr % dta_pkg::YEARS_PER_CENT != 0) || (yr % 400 == 0));
  endfunction

  function automatic int unsigned days_in_month(input int unsigned mon, input int unsigned yr);
    if (mon == dta_pkg::M_FEB) begin
      return leap_year(yr) ? 29 : 28;
    end
    if (mon == dta_pkg::M_APR || mon == dta_pkg::M_JUN || mon == dta_pkg::M_SEP ||
        mon == dta_pkg::M_NOV) begin
      return 30;
    end
    return 31;
  endfunction

  function automatic stamp_t advance_stamp(input logic [4:0] d, input logic [3:0] m,
                                           input logic [13:0] y, input logic [4:0] h,
                                           input logic [5:0] mi, input logic [ADD_W-1:0] add);
    stamp_t      r;
    int unsigned day, mon, yr, tod0, tod1, folded, carried, len;
    bit          ovf;
    tod0 = h;
    tod0 = tod0 * dta_pkg::MIN_PER_HOUR + mi;
    tod1 = tod0 + add;
    carried = tod1 / dta_pkg::MIN_PER_DAY - tod0 / dta_pkg::MIN_PER_DAY;
    folded = tod1 % dta_pkg::MIN_PER_DAY;
    day = d;
    day = day + carried;
    mon = m;
    yr = y;
    ovf = 1'b0;
    len = days_in_month(mon, yr);
    // walk month by month until the day fits
    while (day > len) begin
      day = day - len;
      mon++;
      if (mon > dta_pkg::MONTHS_PER_YEAR) begin
        mon = dta_pkg::M_JAN;
        yr++;
        if (yr > dta_pkg::YEAR_TOP) begin
          yr = 0;
          ovf = 1'b1;
        end
      end
      len = days_in_month(mon, yr);
    end
    r.day = dta_pkg::DAY_W'(day);
    r.month = dta_pkg::MONTH_W'(mon);
    r.year = dta_pkg::YEAR_W'(yr);
    r.hour = dta_pkg::HOUR_W'(folded / dta_pkg::MIN_PER_HOUR);
    r.minute = dta_pkg::MINUTE_W'(folded % dta_pkg::MIN_PER_HOUR);
    r.carried = dta_pkg::CARRY_W'((carried > dta_pkg::CARRY_MAX) ? dta_pkg::CARRY_MAX : carried);
    r.overflow = ovf;
    return r;
  endfunction

  function automatic bit field_ok(input string name, input int unsigned want,
                                  input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    stamp_t want;
    bit     ok;
    if (!rst_n) begin
      stamp_q.delete();
      fail_count = 0;
    end else begin
      // result first: a word leaving and one arriving at the same edge are distinct
      if (out_valid) begin
        if (stamp_q.size() == 0) begin
          $error("result word with nothing pending");
          fail_count++;
        end else begin
          want = stamp_q.pop_front();
          ok = field_ok("new_day", want.day, out_new_day);
          ok &= field_ok("new_month", want.month, out_new_month);
          ok &= field_ok("new_year", want.year, out_new_year);
          ok &= field_ok("new_hour", want.hour, out_new_hour);
          ok &= field_ok("new_minute", want.minute, out_new_minute);
          ok &= field_ok("days_carried", want.carried, out_days_carried);
          ok &= field_ok("year_overflow", want.overflow, out_year_overflow);
          if (!ok) begin
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        stamp_q = {stamp_q, advance_stamp(in_start_day, in_start_month, in_start_year,
                                          in_start_hour, in_start_minute, in_add_minutes)};
      end
    end
    pending = stamp_q.size();
  end

endmodule

// File: tb/date_time_advance_core_tb.sv
`timescale 1ns / 100ps
// testbench top for the date/time advance block: stimulus, watchdog and verdict
module date_time_advance_core_tb;

  localparam int ADD_W = dta_pkg::ADD_MINUTES_WIDTH_DEF;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned WORDS_PER_PHASE = 600;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic [4:0]       in_start_day = '0;
  logic [3:0]       in_start_month = '0;
  logic [13:0]      in_start_year = '0;
  logic [4:0]       in_start_hour = '0;
  logic [5:0]       in_start_minute = '0;
  logic [ADD_W-1:0] in_add_minutes = '0;
  logic             out_valid;
  logic [4:0]       out_new_day;
  logic [3:0]       out_new_month;
  logic [13:0]      out_new_year;
  logic [4:0]       out_new_hour;
  logic [5:0]       out_new_minute;
  logic [5:0]       out_days_carried;
  logic             out_year_overflow;
  int unsigned      fail_count;
  int unsigned      pending;
  int unsigned      quiet_cycles = 0;

  always #5 clk = ~clk;

  date_time_advance_core #(.ADD_MINUTES_WIDTH(ADD_W)) dut (.*);

  date_time_advance_checker #(.ADD_W(ADD_W)) checker_i (.*);

  // run ends if neither side moves a word for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // called at a falling edge; returns at the falling edge after the word is taken
  task automatic send_word(input logic [4:0] d, input logic [3:0] m, input logic [13:0] y,
                           input logic [4:0] h, input logic [5:0] mi,
                           input logic [ADD_W-1:0] add, input int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    in_start_day <= d;
    in_start_month <= m;
    in_start_year <= y;
    in_start_hour <= h;
    in_start_minute <= mi;
    in_add_minutes <= add;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain;
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic send_random(input int unsigned idle_pct);
    logic [4:0]       d;
    logic [3:0]       m;
    logic [13:0]      y;
    logic [4:0]       h;
    logic [5:0]       mi;
    logic [ADD_W-1:0] add;
    int unsigned      len;
    bit               leap;
    if ($urandom_range(99) < 15) begin
      // raw bits: invalid dates, times and years past the top
      d = 5'($urandom);
      m = 4'($urandom);
      y = 14'($urandom);
      h = 5'($urandom);
      mi = 6'($urandom);
      add = ADD_W'($urandom);
    end else begin
      case ($urandom_range(3))
        0: y = 14'(dta_pkg::YEAR_TOP - $urandom_range(1));
        1: y = 14'(dta_pkg::YEARS_PER_CENT * $urandom_range(99));
        default: y = 14'($urandom_range(dta_pkg::YEAR_TOP));
      endcase
      m = 4'($urandom_range(dta_pkg::MONTHS_PER_YEAR, 1));
      leap = (y % 4 == 0) && ((y % dta_pkg::YEARS_PER_CENT != 0) || (y % 400 == 0));
      len = dta_pkg::month_days(m, leap);
      d = 5'($urandom_range(1) ? len - $urandom_range(1) : $urandom_range(len, 1));
      if ($urandom_range(3) == 0) begin
        h = 5'd23;
        mi = 6'(59 - $urandom_range(2));
      end else begin
        h = 5'($urandom_range(23));
        mi = 6'($urandom_range(59));
      end
      case ($urandom_range(3))
        0: add = ADD_W'($urandom_range(dta_pkg::MIN_PER_DAY));
        1: add = ADD_W'(dta_pkg::MIN_PER_DAY * $urandom_range(45) + $urandom_range(3));
        2: add = ADD_W'(((1 << ADD_W) - 1) - $urandom_range(dta_pkg::MIN_PER_DAY));
        default: add = ADD_W'($urandom);
      endcase
    end
    send_word(d, m, y, h, mi, add, idle_pct);
  endtask

  initial begin
    int unsigned phase_idle [3] = '{0, 78, 33};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_word(1, dta_pkg::M_JAN, 2023, 0, 0, 0, 0);
    send_word(31, dta_pkg::M_DEC, 2023, 23, 59, 1, 0);
    send_word(31, dta_pkg::M_DEC, 14'(dta_pkg::YEAR_TOP), 23, 59, 1, 0);
    send_word(28, dta_pkg::M_FEB, 2024, 23, 59, 1, 0);
    send_word(28, dta_pkg::M_FEB, 2023, 23, 59, 1, 0);
    send_word(28, dta_pkg::M_FEB, 1900, 12, 0, 720, 0);
    send_word(28, dta_pkg::M_FEB, 2000, 12, 0, 720, 0);
    send_word(29, dta_pkg::M_FEB, 0, 0, 0, ADD_W'(dta_pkg::MIN_PER_DAY), 0);
    send_word(30, dta_pkg::M_APR, 2021, 0, 0, ADD_W'(dta_pkg::MIN_PER_DAY), 0);
    send_word(0, 0, 0, 0, 0, 0, 0);
    send_word(31, 15, 16383, 31, 63, '1, 0);
    // month zero counts as 31 days
    send_word(15, 0, 2020, 10, 0, ADD_W'(30 * dta_pkg::MIN_PER_DAY), 0);
    // month above december wraps into the next year
    send_word(31, 13, 2020, 0, 0, ADD_W'(dta_pkg::MIN_PER_DAY), 0);
    // day zero kept without carry, replaced with carry
    send_word(0, dta_pkg::M_JUN, 2020, 5, 5, 0, 0);
    send_word(0, dta_pkg::M_JUN, 2020, 23, 0, 120, 0);
    send_word(31, dta_pkg::M_FEB, 2023, 0, 0, 0, 0);
    // years past the top: left alone, then wrapped on advance
    send_word(1, dta_pkg::M_JAN, 12000, 0, 0, 0, 0);
    send_word(31, dta_pkg::M_DEC, 12000, 23, 0, 60, 0);
    // out-of-range time of day
    send_word(1, dta_pkg::M_JAN, 2020, 24, 0, 0, 0);
    send_word(1, dta_pkg::M_JAN, 2020, 31, 63, '1, 0);
    send_word(1, dta_pkg::M_JAN, 2020, 0, 0, '1, 0);
    send_word(1, dta_pkg::M_JAN, 2020, 23, 59, '1, 0);
    send_word(31, dta_pkg::M_JAN, 2020, 0, 0, ADD_W'(29 * dta_pkg::MIN_PER_DAY), 0);
    send_word(15, dta_pkg::M_NOV, 14'(dta_pkg::YEAR_TOP), 0, 0, '1, 0);
    drain();

    for (int p = 0; p < 3; p++) begin
      for (int unsigned n = 0; n < WORDS_PER_PHASE; n++) begin
        send_random(phase_idle[p]);
      end
      drain();
    end

    repeat (100) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      if (pending != 0) begin
        $error("%0d expected words never arrived", pending);
      end
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
